// ----- sv/sic_pkg.sv -----
// Package: widths, constants and helper types for the segment intersection block.
package sic_pkg;
  localparam int CoordW = 16;
  localparam int FracBits = CoordW - 2;
  localparam int DiffW = CoordW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int DetW = ProdW + 1;
  localparam int MagW = DetW;
  localparam int QuoW = FracBits + 1;
  localparam int ThrW = 32;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(268);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [DetW-1:0] det_t;
  typedef logic [MagW-1:0] mag_t;
  typedef logic [QuoW-1:0] quo_t;

  typedef struct packed {
    coord_t seg1_start_x;
    coord_t seg1_start_y;
    coord_t seg1_end_x;
    coord_t seg1_end_y;
    coord_t seg2_start_x;
    coord_t seg2_start_y;
    coord_t seg2_end_x;
    coord_t seg2_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic   found;
    coord_t tip_x;
    coord_t tip_y;
  } tip_t;

  // Per-item side data carried alongside the divider.
  typedef struct packed {
    logic   hit;
    coord_t base_x;
    coord_t base_y;
    diff_t  dx;
    diff_t  dy;
  } side_t;
endpackage

// ----- sv/sic_if.sv -----
// Valid/ready channel interfaces for the segment intersection block.
interface sic_in_if import sic_pkg::*; ();
  logic      valid;
  logic      ready;
  seg_pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sic_out_if import sic_pkg::*; ();
  logic valid;
  logic ready;
  tip_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sic_cfg_if import sic_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ThrW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sic_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, side data travels along.
module sic_div import sic_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  mag_t  in_num,
  input  mag_t  in_den,
  input  side_t in_side,
  output logic  out_valid,
  output quo_t  out_quo,
  output side_t out_side
);
  localparam int Steps = FracBits + 1;

  logic  vld_r  [Steps+1];
  mag_t  rem_r  [Steps+1];
  mag_t  den_r  [Steps+1];
  quo_t  quo_r  [Steps+1];
  side_t side_r [Steps+1];

  // Stage 0 captures the operands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
    if (en) begin
      rem_r[0]  <= in_num;
      den_r[0]  <= in_den;
      quo_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  // Stage 1 handles the whole-unit case, later stages one fraction bit each.
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [MagW:0] trial;
    logic          take;
    always_comb begin
      trial = (s == 0) ? {1'b0, rem_r[s]} : {rem_r[s], 1'b0};
      take  = trial >= {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
        if (s == 0) begin
          // Quotient of one exactly: later steps only shift zeros in.
          rem_r[s+1] <= take ? '0 : rem_r[s];
          quo_r[s+1] <= take ? quo_t'(1) : '0;
        end else begin
          rem_r[s+1] <= take ? MagW'(trial - {1'b0, den_r[s]}) : MagW'(trial);
          quo_r[s+1] <= {quo_r[s][QuoW-2:0], take};
        end
      end
    end
  end

  assign out_valid = vld_r[Steps];
  assign out_quo   = quo_r[Steps];
  assign out_side  = side_r[Steps];
endmodule

// ----- sv/segment_intersection_in_cell.sv -----
// Top level: segment pair intersection test with pipelined division.
//
// Channel  Direction  Payload
// in_      sink       two segments, eight signed Q1.14 coordinates
// out_     source     found flag and intersection point tip_x, tip_y
// cfg_     sink       det_threshold, 32-bit unsigned
//
// One item per cycle sustained while the output is not stalled; the depth is
// set mostly by the one-bit-per-stage divider. Reset clears all valid bits and loads
// det_threshold with 268. A stall at the output freezes the whole pipeline
// through one shared enable; no transaction is lost or repeated.
module segment_intersection_in_cell import sic_pkg::*; (
  input logic clk,
  input logic rst_n,
  sic_in_if.sink    in_ch,
  sic_out_if.source out_ch,
  sic_cfg_if.sink   cfg_ch
);
  logic            en;
  logic [ThrW-1:0] thr_r;

  // Pipeline advances unless the output register holds an untaken result.
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrReset;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.data;
    end
  end

  // Stage 1: differences.
  logic  v1_r;
  diff_t a11_r, a12_r, a21_r, a22_r, d1_r, d2_r;
  coord_t pex1_r, pey1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
    if (en) begin
      a11_r  <= DiffW'(in_ch.data.seg1_start_x) - DiffW'(in_ch.data.seg1_end_x);
      a21_r  <= DiffW'(in_ch.data.seg1_start_y) - DiffW'(in_ch.data.seg1_end_y);
      a12_r  <= DiffW'(in_ch.data.seg2_end_x) - DiffW'(in_ch.data.seg2_start_x);
      a22_r  <= DiffW'(in_ch.data.seg2_end_y) - DiffW'(in_ch.data.seg2_start_y);
      d1_r   <= DiffW'(in_ch.data.seg2_end_x) - DiffW'(in_ch.data.seg1_end_x);
      d2_r   <= DiffW'(in_ch.data.seg2_end_y) - DiffW'(in_ch.data.seg1_end_y);
      pex1_r <= in_ch.data.seg1_end_x;
      pey1_r <= in_ch.data.seg1_end_y;
    end
  end

  // Stage 2: six products.
  logic  v2_r;
  prod_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  diff_t a11_2_r, a21_2_r;
  coord_t pex2_r, pey2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      p0_r <= prod_t'(a11_r) * prod_t'(a22_r);
      p1_r <= prod_t'(a12_r) * prod_t'(a21_r);
      p2_r <= prod_t'(d1_r) * prod_t'(a22_r);
      p3_r <= prod_t'(a12_r) * prod_t'(d2_r);
      p4_r <= prod_t'(d2_r) * prod_t'(a11_r);
      p5_r <= prod_t'(a21_r) * prod_t'(d1_r);
      a11_2_r <= a11_r;
      a21_2_r <= a21_r;
      pex2_r  <= pex1_r;
      pey2_r  <= pey1_r;
    end
  end

  // Stage 3: determinant and numerators.
  logic v3_r;
  det_t det_r, nu_r, nv_r;
  diff_t a11_3_r, a21_3_r;
  coord_t pex3_r, pey3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      det_r   <= DetW'(p0_r) - DetW'(p1_r);
      nu_r    <= DetW'(p2_r) - DetW'(p3_r);
      nv_r    <= DetW'(p4_r) - DetW'(p5_r);
      a11_3_r <= a11_2_r;
      a21_3_r <= a21_2_r;
      pex3_r  <= pex2_r;
      pey3_r  <= pey2_r;
    end
  end

  // Stage 4: magnitudes and range tests.
  mag_t  adet, anu, anv;
  logic  hit;
  side_t side4;
  always_comb begin
    adet = det_r[DetW-1] ? mag_t'(-det_r) : mag_t'(det_r);
    anu  = nu_r[DetW-1] ? mag_t'(-nu_r) : mag_t'(nu_r);
    anv  = nv_r[DetW-1] ? mag_t'(-nv_r) : mag_t'(nv_r);
    hit  = (adet != '0) && (adet >= mag_t'(thr_r))
        && ((nu_r == '0) || ((nu_r[DetW-1] == det_r[DetW-1]) && (anu <= adet)))
        && ((nv_r == '0) || ((nv_r[DetW-1] == det_r[DetW-1]) && (anv <= adet)));
    side4.hit    = hit;
    side4.base_x = pex3_r;
    side4.base_y = pey3_r;
    side4.dx     = a11_3_r;
    side4.dy     = a21_3_r;
  end

  logic  dv;
  quo_t  dq;
  side_t dside;
  sic_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (hit ? anu : '0),
    .in_den    (hit ? adet : mag_t'(1)),
    .in_side   (side4),
    .out_valid (dv),
    .out_quo   (dq),
    .out_side  (dside)
  );

  // Interpolation products.
  localparam int IpW = QuoW + DiffW + 1;
  logic v5_r;
  logic signed [IpW-1:0] ipx_r, ipy_r;
  side_t s5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= dv;
    if (en) begin
      ipx_r <= $signed({1'b0, dq}) * IpW'(dside.dx);
      ipy_r <= $signed({1'b0, dq}) * IpW'(dside.dy);
      s5_r  <= dside;
    end
  end

  // Rounding, offset and saturation into the output register.
  localparam int SumW = IpW - FracBits + 2;
  logic signed [IpW-1:0]  rx, ry;
  logic signed [SumW-1:0] sx, sy;
  coord_t tx, ty;
  localparam logic signed [SumW-1:0] CMax = SumW'((1 << (CoordW - 1)) - 1);
  localparam logic signed [SumW-1:0] CMin = -CMax - SumW'(1);
  always_comb begin
    rx = (ipx_r + IpW'(1 << (FracBits - 1))) >>> FracBits;
    ry = (ipy_r + IpW'(1 << (FracBits - 1))) >>> FracBits;
    sx = SumW'(rx) + SumW'(s5_r.base_x);
    sy = SumW'(ry) + SumW'(s5_r.base_y);
    tx = (sx > CMax) ? coord_t'(CMax) : (sx < CMin) ? coord_t'(CMin) : coord_t'(sx);
    ty = (sy > CMax) ? coord_t'(CMax) : (sy < CMin) ? coord_t'(CMin) : coord_t'(sy);
  end

  logic out_v_r;
  tip_t out_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= v5_r;
    if (en) begin
      out_d_r.found <= s5_r.hit;
      out_d_r.tip_x <= s5_r.hit ? tx : '0;
      out_d_r.tip_y <= s5_r.hit ? ty : '0;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;
endmodule
